// ===== rtl/pmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared constants, types and codes for the polynomial convolver.
// ----------------------------------------------------------------------------
package pmc_pkg;

    localparam int MAX_TERMS_DEF   = 16;
    localparam int COEFF_WIDTH_DEF = 16;
    localparam int ACC_W           = 36;
    localparam int DEG_W           = 5;

    localparam logic REQ_FIRST  = 1'b0;
    localparam logic REQ_SECOND = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FLUSH = 2'b10
    } pmc_state_t;

    // broadcast controls for the cell row
    typedef struct packed {
        logic clear;
        logic mac;
        logic mac_shift;
        logic shift;
    } pmc_cell_ctrl_t;

endpackage

// ===== rtl/polynomial_multiply_convolver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_multiply_convolver_unit
// Linear convolution of two integer polynomials on a row of MAC cells.
// ----------------------------------------------------------------------------
// First-polynomial beat: no result.
// Second-polynomial beat: its product coefficient is registered and offered
//   the cycle after acceptance; one beat per cycle while results are taken.
// Last second beat: the cell row drains through cell 0, one result per cycle
//   while results are taken (first_count results); next beat after the drain.
// Reset: control, counters and partial sums clear; held terms are undefined.
module polynomial_multiply_convolver_unit #(
    parameter int MAX_TERMS   = pmc_pkg::MAX_TERMS_DEF,
    parameter int COEFF_WIDTH = pmc_pkg::COEFF_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic                             req_type,
    input  logic signed [COEFF_WIDTH-1:0]    coeff_in,
    input  logic                             last_coeff,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic signed [pmc_pkg::ACC_W-1:0] product_coeff,
    output logic        [pmc_pkg::DEG_W-1:0] degree,
    output logic                             last_in_run,
    output logic                             error
);
    import pmc_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    pmc_state_t       state_reg, state_next;
    logic [CNT_W-1:0] first_count_reg, first_count_next;
    logic             first_complete_reg, first_complete_next;
    logic [CNT_W-1:0] second_count_reg, second_count_next;
    logic [CNT_W-1:0] flush_idx_reg, flush_idx_next;

    logic             result_valid_reg, result_valid_next;
    logic [ACC_W-1:0] product_reg, product_next;
    logic [DEG_W-1:0] degree_reg, degree_next;
    logic             last_reg, last_next;
    logic             error_reg, error_next;

    pmc_cell_ctrl_t   ctrl;
    logic             load_en;
    logic [CNT_W-1:0] load_idx;
    logic             slot_free;
    logic             accept;
    logic             flush_last;
    logic             restart;

    logic [ACC_W-1:0] mac_vals  [MAX_TERMS];
    logic [ACC_W-1:0] psum_vals [MAX_TERMS];

    assign slot_free  = !result_valid_reg || result_ready;
    assign item_ready = (state_reg == ST_IDLE) && slot_free;
    assign accept     = item_valid && item_ready;
    assign restart    = first_complete_reg;
    assign load_idx   = restart ? '0 : first_count_reg;
    assign flush_last = (flush_idx_reg == first_count_reg - CNT_W'(1));

    always_comb
    begin
        state_next          = state_reg;
        first_count_next    = first_count_reg;
        first_complete_next = first_complete_reg;
        second_count_next   = second_count_reg;
        flush_idx_next      = flush_idx_reg;
        result_valid_next   = result_valid_reg && !result_ready;
        product_next        = product_reg;
        degree_next         = degree_reg;
        last_next           = last_reg;
        error_next          = error_reg;
        ctrl                = '0;
        load_en             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_FIRST)
                    begin
                        if (restart)
                        begin
                            ctrl.clear        = 1'b1;
                            second_count_next = '0;
                        end
                        if (load_idx < CNT_W'(MAX_TERMS))
                        begin
                            load_en          = 1'b1;
                            first_count_next = load_idx + CNT_W'(1);
                        end
                        else
                        begin
                            first_count_next = load_idx;
                        end
                        first_complete_next = last_coeff;
                    end
                    else
                    begin
                        first_complete_next = 1'b1;
                        result_valid_next   = 1'b1;
                        error_next          = 1'b0;
                        degree_next         = DEG_W'(second_count_reg);
                        if (second_count_reg >= CNT_W'(MAX_TERMS))
                        begin
                            product_next = '0;
                            degree_next  = '0;
                            last_next    = 1'b0;
                            error_next   = 1'b1;
                        end
                        else if (first_count_reg == '0)
                        begin
                            product_next      = '0;
                            last_next         = last_coeff;
                            second_count_next = last_coeff ? '0
                                                : second_count_reg + CNT_W'(1);
                        end
                        else if (!last_coeff)
                        begin
                            ctrl.mac_shift    = 1'b1;
                            product_next      = mac_vals[0];
                            last_next         = 1'b0;
                            second_count_next = second_count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ctrl.mac          = 1'b1;
                            result_valid_next = result_valid_reg && !result_ready;
                            flush_idx_next    = '0;
                            state_next        = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    ctrl.shift        = 1'b1;
                    result_valid_next = 1'b1;
                    product_next      = psum_vals[0];
                    degree_next       = DEG_W'(second_count_reg) + DEG_W'(flush_idx_reg);
                    last_next         = flush_last;
                    error_next        = 1'b0;
                    if (flush_last)
                    begin
                        second_count_next = '0;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        flush_idx_next = flush_idx_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            first_count_reg    <= '0;
            first_complete_reg <= 1'b0;
            second_count_reg   <= '0;
            flush_idx_reg      <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            first_count_reg    <= first_count_next;
            first_complete_reg <= first_complete_next;
            second_count_reg   <= second_count_next;
            flush_idx_reg      <= flush_idx_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        degree_reg  <= degree_next;
        last_reg    <= last_next;
        error_reg   <= error_next;
    end

    for (genvar i = 0; i < MAX_TERMS; i++)
    begin : g_cell
        logic [ACC_W-1:0] nb_mac;
        logic [ACC_W-1:0] nb_psum;

        if (i == MAX_TERMS - 1)
        begin : g_end
            assign nb_mac  = '0;
            assign nb_psum = '0;
        end
        else
        begin : g_mid
            assign nb_mac  = mac_vals[i+1];
            assign nb_psum = psum_vals[i+1];
        end

        pmc_cell #(
            .COEFF_WIDTH (COEFF_WIDTH)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .load          (load_en && (load_idx == CNT_W'(i))),
            .active        (CNT_W'(i) < first_count_reg),
            .coeff         (coeff_in),
            .shift_mac_in  (nb_mac),
            .shift_psum_in (nb_psum),
            .mac_out       (mac_vals[i]),
            .psum_out      (psum_vals[i])
        );
    end

    assign result_valid  = result_valid_reg;
    assign product_coeff = product_reg;
    assign degree        = degree_reg;
    assign last_in_run   = last_reg;
    assign error         = error_reg;

    a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> !item_ready)
        else $error("input taken during drain");

    a_flush_has_terms: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (first_count_reg != '0)
                                    && (flush_idx_reg < first_count_reg))
        else $error("drain index out of range");

    a_first_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        first_count_reg <= CNT_W'(MAX_TERMS))
        else $error("first term count overflow");

    a_second_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        second_count_reg <= CNT_W'(MAX_TERMS))
        else $error("second term count overflow");

    a_drain_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && slot_free && flush_last)
        |=> (state_reg == ST_IDLE) && (second_count_reg == '0) && result_valid_reg)
        else $error("run not closed after drain");

endmodule

// ===== rtl/pmc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_cell
// One convolution cell: holds one first-polynomial term and one window
// partial sum, multiplies-accumulates and shifts toward the output end.
// ----------------------------------------------------------------------------
module pmc_cell #(
    parameter int COEFF_WIDTH = pmc_pkg::COEFF_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pmc_pkg::pmc_cell_ctrl_t          ctrl,
    input  logic                             load,
    input  logic                             active,
    input  logic signed [COEFF_WIDTH-1:0]    coeff,
    input  logic        [pmc_pkg::ACC_W-1:0] shift_mac_in,
    input  logic        [pmc_pkg::ACC_W-1:0] shift_psum_in,
    output logic        [pmc_pkg::ACC_W-1:0] mac_out,
    output logic        [pmc_pkg::ACC_W-1:0] psum_out
);
    import pmc_pkg::*;

    logic signed [COEFF_WIDTH-1:0]   term_reg;
    logic signed [2*COEFF_WIDTH-1:0] product;
    logic signed [ACC_W-1:0]         product_ext;
    logic        [ACC_W-1:0]         psum_reg;
    logic        [ACC_W-1:0]         psum_next;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            term_reg <= coeff;
        end
    end

    assign product     = term_reg * coeff;
    assign product_ext = ACC_W'(product);
    assign mac_out     = active ? (psum_reg + ACC_W'(product_ext)) : psum_reg;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            psum_next = '0;
        end
        else if (ctrl.mac_shift)
        begin
            psum_next = shift_mac_in;
        end
        else if (ctrl.mac)
        begin
            psum_next = mac_out;
        end
        else if (ctrl.shift)
        begin
            psum_next = shift_psum_in;
        end
        else
        begin
            psum_next = psum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psum_reg <= '0;
        end
        else
        begin
            psum_reg <= psum_next;
        end
    end

    assign psum_out = psum_reg;

endmodule

// ===== bench/convolver_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convolver_check
// Watches both channels of the polynomial convolver. Every accepted input beat
// updates a local copy of the held terms and the partial-sum window and
// queues the product terms it yields. Every accepted result beat is compared,
// field by field, against the oldest queued term.
// ----------------------------------------------------------------------------
module convolver_check #(
    parameter int MAX_TERMS   = pmc_pkg::MAX_TERMS_DEF,
    parameter int COEFF_WIDTH = pmc_pkg::COEFF_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_ready,
    input  logic                             req_type,
    input  logic signed [COEFF_WIDTH-1:0]    coeff_in,
    input  logic                             last_coeff,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  logic signed [pmc_pkg::ACC_W-1:0] product_coeff,
    input  logic        [pmc_pkg::DEG_W-1:0] degree,
    input  logic                             last_in_run,
    input  logic                             error,
    output int                               fail_count,
    output int                               pending
);
    import pmc_pkg::*;

    typedef struct packed {
        logic [ACC_W-1:0] coeff;
        logic [DEG_W-1:0] deg;
        logic             last;
        logic             err;
    } product_term_t;

    logic signed [COEFF_WIDTH-1:0] held_terms [MAX_TERMS];
    int                            held_count;
    bit                            held_closed;
    logic [ACC_W-1:0]              window [MAX_TERMS];
    int                            run_count;
    product_term_t                 expected_terms [$];

    task automatic push_term(input logic [ACC_W-1:0] value, input int deg,
                             input logic lst, input logic err);
        product_term_t t;
        t.coeff = value;
        t.deg   = deg[DEG_W-1:0];
        t.last  = lst;
        t.err   = err;
        expected_terms.push_back(t);
    endtask

    task automatic clear_window();
        int k;
        for (k = 0; k < MAX_TERMS; k++)
            window[k] = '0;
        run_count = 0;
    endtask

    task automatic predict_products(input logic kind,
                                    input logic signed [COEFF_WIDTH-1:0] c,
                                    input logic lst);
        int     k;
        longint prod;
        if (kind == REQ_FIRST)
        begin
            if (held_closed)
            begin
                held_count  = 0;
                held_closed = 0;
                clear_window();
            end
            if (held_count < MAX_TERMS)
            begin
                held_terms[held_count] = c;
                held_count++;
            end
            if (lst)
                held_closed = 1;
        end
        else
        begin
            held_closed = 1;
            if (run_count >= MAX_TERMS)
                push_term('0, 0, 1'b0, 1'b1);
            else if (held_count == 0)
            begin
                push_term('0, run_count, lst, 1'b0);
                run_count++;
                if (lst)
                    clear_window();
            end
            else
            begin
                for (k = 0; k < held_count; k++)
                begin
                    prod = longint'(held_terms[k]) * longint'(c);
                    window[k] = window[k] + prod[ACC_W-1:0];
                end
                if (!lst)
                begin
                    push_term(window[0], run_count, 1'b0, 1'b0);
                    for (k = 0; k + 1 < MAX_TERMS; k++)
                        window[k] = window[k + 1];
                    window[MAX_TERMS-1] = '0;
                    run_count++;
                end
                else
                begin
                    for (k = 0; k < held_count; k++)
                        push_term(window[k], run_count + k, (k + 1 == held_count), 1'b0);
                    clear_window();
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        product_term_t want;
        if (!rst_n)
        begin
            held_count  = 0;
            held_closed = 0;
            clear_window();
            expected_terms.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                predict_products(req_type, coeff_in, last_coeff);
            if (result_valid && result_ready)
            begin
                if (expected_terms.size() == 0)
                begin
                    $display("%0t: unexpected result beat: coeff=%0d deg=%0d last=%0b err=%0b",
                             $time, product_coeff, degree, last_in_run, error);
                    fail_count++;
                end
                else
                begin
                    want = expected_terms.pop_front();
                    if (want.coeff !== product_coeff || want.deg !== degree ||
                        want.last !== last_in_run || want.err !== error)
                    begin
                        $display("%0t: mismatch: expected coeff=%0d deg=%0d last=%0b err=%0b",
                                 $time, $signed(want.coeff), want.deg, want.last, want.err);
                        $display("%0t:           actual coeff=%0d deg=%0d last=%0b err=%0b",
                                 $time, product_coeff, degree, last_in_run, error);
                        fail_count++;
                    end
                end
            end
            pending = expected_terms.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for polynomial_multiply_convolver_unit. A directed
// opening covers the empty first polynomial, coefficient extremes, reuse of a
// held polynomial, a second polynomial that closes the first and a single-term
// product. Random polynomial pairs, term-limit overruns and noise follow, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
    import pmc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 115;
    localparam int DRAIN_CYCLES = 40;

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_ready;
    logic                    req_type;
    logic signed [15:0]      coeff_in;
    logic                    last_coeff;
    logic                    result_valid;
    logic                    result_ready;
    logic signed [ACC_W-1:0] product_coeff;
    logic        [DEG_W-1:0] degree;
    logic                    last_in_run;
    logic                    error;

    int fail_count;
    int pending;
    int items_sent;
    int cycle_count;
    bit no_idle;

    polynomial_multiply_convolver_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .req_type      (req_type),
        .coeff_in      (coeff_in),
        .last_coeff    (last_coeff),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .product_coeff (product_coeff),
        .degree        (degree),
        .last_in_run   (last_in_run),
        .error         (error)
    );

    convolver_check u_convolver_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .req_type      (req_type),
        .coeff_in      (coeff_in),
        .last_coeff    (last_coeff),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .product_coeff (product_coeff),
        .degree        (degree),
        .last_in_run   (last_in_run),
        .error         (error),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** polynomial_multiply_convolver_unit: FAILED **");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [15:0] random_coeff();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return -16'sd32768;
        else if (r == 1)
            return 16'sd32767;
        else if (r == 2)
            return 16'sd0;
        else
            return 16'($urandom());
    endfunction

    function automatic int pick_len(input int max_len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 5);
        else if (r < 95)
            return $urandom_range(6, max_len - 1);
        else
            return max_len;
    endfunction

    // result side: mostly ready, with short and occasional long stalls
    initial
    begin
        int hold;
        hold = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!no_idle && hold == 0 && $urandom_range(0, 99) < 25)
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(1, 3);
            if (hold > 0)
            begin
                result_ready <= 1'b0;
                hold--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // entered and left at a falling edge
    task automatic send_coeff(input logic kind, input logic signed [15:0] c,
                              input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        req_type   <= kind;
        coeff_in   <= c;
        last_coeff <= lst;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_first_poly(input int len, input bit mark_last);
        int k;
        for (k = 0; k < len; k++)
            send_coeff(REQ_FIRST, random_coeff(), mark_last && (k == len - 1));
    endtask

    task automatic send_second_poly(input int len, input bit mark_last);
        int k;
        for (k = 0; k < len; k++)
            send_coeff(REQ_SECOND, random_coeff(), mark_last && (k == len - 1));
    endtask

    task automatic run_sequence(input int kind_sel);
        int k;
        int runs;
        if (kind_sel < 70)
        begin
            if ($urandom_range(0, 19) == 0)
                send_first_poly($urandom_range(17, 20), 1'b1);
            else
                send_first_poly(pick_len(MAX_TERMS_DEF), $urandom_range(0, 9) != 0);
            runs = $urandom_range(1, 3);
            for (k = 0; k < runs; k++)
                send_second_poly(pick_len(MAX_TERMS_DEF), 1'b1);
        end
        else if (kind_sel < 82)
        begin
            send_first_poly($urandom_range(1, 4), 1'b1);
            send_second_poly(MAX_TERMS_DEF + $urandom_range(1, 3),
                             1'($urandom_range(0, 1)));
        end
        else
        begin
            runs = $urandom_range(3, 8);
            for (k = 0; k < runs; k++)
                send_coeff(1'($urandom_range(0, 1)), random_coeff(),
                           1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int seq_idx;
        int random_end;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        req_type   = REQ_FIRST;
        coeff_in   = '0;
        last_coeff = 1'b0;
        no_idle    = 1'b0;
        items_sent = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty first polynomial
        send_coeff(REQ_SECOND, 16'sd5, 1'b0);
        send_coeff(REQ_SECOND, -16'sd1, 1'b1);
        // extremes
        send_coeff(REQ_FIRST, -16'sd32768, 1'b0);
        send_coeff(REQ_FIRST, 16'sd32767, 1'b1);
        send_coeff(REQ_SECOND, -16'sd32768, 1'b0);
        send_coeff(REQ_SECOND, -16'sd32768, 1'b0);
        send_coeff(REQ_SECOND, 16'sd32767, 1'b1);
        // held polynomial reused
        send_coeff(REQ_SECOND, 16'sd1, 1'b1);
        // second polynomial closes an open first one
        send_coeff(REQ_FIRST, 16'sd3, 1'b0);
        send_coeff(REQ_FIRST, -16'sd2, 1'b0);
        send_coeff(REQ_SECOND, 16'sd7, 1'b1);
        // single-term product
        send_coeff(REQ_FIRST, -16'sd1, 1'b1);
        send_coeff(REQ_SECOND, -16'sd32768, 1'b1);

        random_end = items_sent + RANDOM_ITEMS;
        seq_idx = 0;
        while (items_sent < random_end)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if (seq_idx == 0)
                run_sequence(75);
            else if (seq_idx == 1)
            begin
                send_first_poly($urandom_range(17, 20), 1'b1);
                send_second_poly(pick_len(MAX_TERMS_DEF), 1'b1);
            end
            else
                run_sequence($urandom_range(0, 99));
            seq_idx++;
        end
        item_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("** polynomial_multiply_convolver_unit: PASSED **");
        else
            $display("** polynomial_multiply_convolver_unit: FAILED **");
        $finish;
    end

endmodule
